/* rtl/eblz_pkg.sv */
// ---------------------------------------------------------------------------
// Escape-byte LZ decoder package
// Shared constants, word types, command format and state encodings.
// ---------------------------------------------------------------------------
package eblz_pkg;

    localparam int HIST_DEPTH   = 256;
    localparam int HIST_AW      = $clog2(HIST_DEPTH);
    localparam int LANES        = 4;
    localparam int LANE_W       = $clog2(LANES);
    localparam int HEADER_BYTES = 12;
    localparam int FIFO_DEPTH   = 4;
    localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

    typedef enum logic [2:0] {
        ST_RUNNING       = 3'd0,
        ST_DONE_OK       = 3'd1,
        ST_HDR_SHORT     = 3'd2,
        ST_OVERFLOW      = 3'd3,
        ST_TRUNCATED     = 3'd4,
        ST_ZERO_OFFSET   = 3'd5,
        ST_BEFORE_START  = 3'd6,
        ST_SIZE_MISMATCH = 3'd7
    } status_t;

    typedef enum logic [1:0] {
        PH_TOKEN,
        PH_ESCAPE,
        PH_LENGTH
    } phase_t;

    typedef enum logic {
        FR_TAKE,
        FR_EVAL
    } front_state_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_WRITE
    } back_state_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_t;

    typedef struct packed {
        logic [7:0] out_byte0;
        logic [7:0] out_byte1;
        logic [7:0] out_byte2;
        logic [7:0] out_byte3;
        logic [2:0] out_count;
        logic       run_last;
        logic [2:0] status;
    } out_t;

    // One unit of work for the back end: a literal, a copy or a bare status.
    typedef struct packed {
        logic               is_lit;
        logic [7:0]         lit_byte;
        logic [7:0]         len;
        logic [7:0]         off;
        logic [HIST_AW-1:0] base;
        status_t            status;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_flags_t;

endpackage

/* rtl/eblz_front.sv */
// ---------------------------------------------------------------------------
// Escape-byte LZ decoder front end
// Accepts stream bytes, parses the header and tokens, checks sizes and
// issues literal, copy and status commands to the back end.
// ---------------------------------------------------------------------------
module eblz_front (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  eblz_pkg::in_t      s_data,
    output logic               push,
    output eblz_pkg::cmd_t     push_cmd,
    input  eblz_pkg::q_flags_t q_flags
);

    localparam int AW = eblz_pkg::HIST_AW;

    eblz_pkg::front_state_t state_reg, state_next;
    eblz_pkg::phase_t       phase_reg, phase_next;
    logic [7:0]  byte_reg, byte_next;
    logic        last_reg, last_next;
    logic        hdr_reg, hdr_next;
    logic [3:0]  hidx_reg, hidx_next;
    logic [31:0] src_reg, src_next;
    logic [31:0] size_reg, size_next;
    logic [31:0] exp_reg, exp_next;
    logic [31:0] esc_reg, esc_next;
    logic [31:0] pos_reg, pos_next;
    logic [31:0] remain_reg, remain_next;
    logic [7:0]  off_reg, off_next;
    logic        ended_reg, ended_next;

    logic             esc_match;
    logic             esc_lt;
    logic [7:0]       adj_off;
    logic             src_done;
    logic             len_gt_remain;
    logic             pos_lt_off;
    eblz_pkg::status_t st;

    function automatic eblz_pkg::status_t boundary(input logic done, input logic full,
                                                   input logic last);
        if (done) begin
            return full ? eblz_pkg::ST_DONE_OK : eblz_pkg::ST_SIZE_MISMATCH;
        end else if (full) begin
            return eblz_pkg::ST_OVERFLOW;
        end else if (last) begin
            return eblz_pkg::ST_TRUNCATED;
        end
        return eblz_pkg::ST_RUNNING;
    endfunction

    assign esc_match     = (esc_reg[31:8] == 24'd0) && (esc_reg[7:0] == byte_reg);
    assign esc_lt        = (esc_reg[31:8] == 24'd0) && (esc_reg[7:0] < byte_reg);
    assign adj_off       = byte_reg - {7'd0, esc_lt};
    assign src_done      = (src_reg >= size_reg);
    assign len_gt_remain = (remain_reg < {24'd0, byte_reg});
    assign pos_lt_off    = (pos_reg < {24'd0, off_reg});

    always_comb begin
        state_next  = state_reg;
        phase_next  = phase_reg;
        byte_next   = byte_reg;
        last_next   = last_reg;
        hdr_next    = hdr_reg;
        hidx_next   = hidx_reg;
        src_next    = src_reg;
        size_next   = size_reg;
        exp_next    = exp_reg;
        esc_next    = esc_reg;
        pos_next    = pos_reg;
        remain_next = remain_reg;
        off_next    = off_reg;
        ended_next  = ended_reg;
        s_ready     = (state_reg == eblz_pkg::FR_TAKE);
        push        = 1'b0;
        st          = eblz_pkg::ST_RUNNING;
        push_cmd          = '0;
        push_cmd.base     = pos_reg[AW-1:0];
        push_cmd.off      = off_reg;
        push_cmd.lit_byte = byte_reg;
        push_cmd.status   = eblz_pkg::ST_RUNNING;

        case (state_reg)
            eblz_pkg::FR_TAKE: begin
                if (s_valid) begin
                    byte_next = s_data.in_byte;
                    last_next = s_data.in_last;
                    hdr_next  = (src_reg < 32'(eblz_pkg::HEADER_BYTES));
                    hidx_next = src_reg[3:0];
                    if (!ended_reg && (src_reg != 32'hFFFF_FFFF)) begin
                        src_next = src_reg + 32'd1;
                    end
                    state_next = eblz_pkg::FR_EVAL;
                end
            end
            eblz_pkg::FR_EVAL: begin
                if (!q_flags.full) begin
                    state_next = eblz_pkg::FR_TAKE;
                    if (!ended_reg) begin
                        if (hdr_reg) begin
                            case (hidx_reg[3:2])
                                2'd0: begin
                                    exp_next[8*hidx_reg[1:0] +: 8]    = byte_reg;
                                    remain_next[8*hidx_reg[1:0] +: 8] = byte_reg;
                                end
                                2'd1: size_next[8*hidx_reg[1:0] +: 8] = byte_reg;
                                default: esc_next[8*hidx_reg[1:0] +: 8] = byte_reg;
                            endcase
                            if (hidx_reg == 4'(eblz_pkg::HEADER_BYTES - 1)) begin
                                st = boundary(src_done, remain_reg == 32'd0, last_reg);
                            end else if (last_reg) begin
                                st = eblz_pkg::ST_HDR_SHORT;
                            end
                        end else begin
                            case (phase_reg)
                                eblz_pkg::PH_TOKEN: begin
                                    if (esc_match) begin
                                        phase_next = eblz_pkg::PH_ESCAPE;
                                        if (last_reg) begin
                                            st = eblz_pkg::ST_TRUNCATED;
                                        end
                                    end else begin
                                        push_cmd.is_lit = 1'b1;
                                        push_cmd.len    = 8'd1;
                                        pos_next        = pos_reg + 32'd1;
                                        remain_next     = remain_reg - 32'd1;
                                        st = boundary(src_done, remain_reg == 32'd1, last_reg);
                                    end
                                end
                                eblz_pkg::PH_ESCAPE: begin
                                    if (esc_match) begin
                                        // Doubled escape byte stands for itself.
                                        push_cmd.is_lit = 1'b1;
                                        push_cmd.len    = 8'd1;
                                        pos_next        = pos_reg + 32'd1;
                                        remain_next     = remain_reg - 32'd1;
                                        phase_next      = eblz_pkg::PH_TOKEN;
                                        st = boundary(src_done, remain_reg == 32'd1, last_reg);
                                    end else if (adj_off == 8'd0) begin
                                        st = eblz_pkg::ST_ZERO_OFFSET;
                                    end else begin
                                        off_next   = adj_off;
                                        phase_next = eblz_pkg::PH_LENGTH;
                                        if (last_reg) begin
                                            st = eblz_pkg::ST_TRUNCATED;
                                        end
                                    end
                                end
                                eblz_pkg::PH_LENGTH: begin
                                    phase_next = eblz_pkg::PH_TOKEN;
                                    if (byte_reg == 8'd0) begin
                                        st = boundary(src_done, remain_reg == 32'd0, last_reg);
                                    end else if (pos_lt_off) begin
                                        st = eblz_pkg::ST_BEFORE_START;
                                    end else if (len_gt_remain) begin
                                        st = eblz_pkg::ST_OVERFLOW;
                                    end else begin
                                        push_cmd.len = byte_reg;
                                        pos_next     = pos_reg + {24'd0, byte_reg};
                                        remain_next  = remain_reg - {24'd0, byte_reg};
                                        st = boundary(src_done,
                                                      remain_reg == {24'd0, byte_reg},
                                                      last_reg);
                                    end
                                end
                                default: phase_next = eblz_pkg::PH_TOKEN;
                            endcase
                        end
                        push_cmd.status = st;
                        push = (push_cmd.len != 8'd0) || (st != eblz_pkg::ST_RUNNING);
                        if (st != eblz_pkg::ST_RUNNING) begin
                            ended_next = 1'b1;
                        end
                    end
                    // The last word of a buffer re-arms the parser once the stream
                    // has ended; the history is kept.
                    if (last_reg && (ended_reg || (st != eblz_pkg::ST_RUNNING))) begin
                        phase_next  = eblz_pkg::PH_TOKEN;
                        src_next    = '0;
                        size_next   = '0;
                        exp_next    = '0;
                        esc_next    = '0;
                        pos_next    = '0;
                        remain_next = '0;
                        off_next    = '0;
                        ended_next  = 1'b0;
                    end
                end
            end
            default: state_next = eblz_pkg::FR_TAKE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= eblz_pkg::FR_TAKE;
            phase_reg  <= eblz_pkg::PH_TOKEN;
            src_reg    <= '0;
            size_reg   <= '0;
            exp_reg    <= '0;
            esc_reg    <= '0;
            pos_reg    <= '0;
            remain_reg <= '0;
            off_reg    <= '0;
            ended_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            src_reg    <= src_next;
            size_reg   <= size_next;
            exp_reg    <= exp_next;
            esc_reg    <= esc_next;
            pos_reg    <= pos_next;
            remain_reg <= remain_next;
            off_reg    <= off_next;
            ended_reg  <= ended_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
        last_reg <= last_next;
        hdr_reg  <= hdr_next;
        hidx_reg <= hidx_next;
    end

endmodule

/* rtl/eblz_fifo.sv */
// ---------------------------------------------------------------------------
// Escape-byte LZ decoder command queue
// Short first-in first-out queue of commands between front and back end.
// ---------------------------------------------------------------------------
module eblz_fifo (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  eblz_pkg::cmd_t     push_cmd,
    input  logic               pop,
    output eblz_pkg::cmd_t     head,
    output eblz_pkg::q_flags_t q_flags
);

    localparam int AW    = eblz_pkg::FIFO_AW;
    localparam int DEPTH = eblz_pkg::FIFO_DEPTH;

    eblz_pkg::cmd_t slot_reg [DEPTH];
    logic [AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [AW:0]    count_reg, count_next;

    assign head          = slot_reg[rd_ptr_reg];
    assign q_flags.full  = (count_reg == (AW+1)'(DEPTH));
    assign q_flags.empty = (count_reg == '0);

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + AW'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + AW'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + (AW+1)'(1);
            2'b01:   count_next = count_reg - (AW+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* rtl/eblz_back.sv */
// ---------------------------------------------------------------------------
// Escape-byte LZ decoder back end
// Executes commands byte by byte against the history memory and packs the
// decoded bytes into output words held in an output register.
// ---------------------------------------------------------------------------
module eblz_back (
    input  logic               aclk,
    input  logic               aresetn,
    input  eblz_pkg::cmd_t     head,
    input  eblz_pkg::q_flags_t q_flags,
    output logic               pop,
    output logic               m_valid,
    input  logic               m_ready,
    output eblz_pkg::out_t     m_data
);

    localparam int AW    = eblz_pkg::HIST_AW;
    localparam int DEPTH = eblz_pkg::HIST_DEPTH;
    localparam int LW    = eblz_pkg::LANE_W;
    localparam int NL    = eblz_pkg::LANES;

    eblz_pkg::back_state_t state_reg, state_next;
    eblz_pkg::cmd_t        cmd_reg, cmd_next;
    logic [7:0]            k_reg, k_next;
    logic [LW-1:0]         lane_reg, lane_next;
    logic [7:0]            lanes_reg [NL];
    logic [7:0]            hist_mem [DEPTH];
    logic [7:0]            rd_data_reg;
    logic                  m_valid_reg;
    eblz_pkg::out_t        m_data_reg;

    logic           can_load;
    logic           load_beat;
    logic           rd_en;
    logic           wr_en;
    logic [AW-1:0]  wr_addr;
    logic [AW-1:0]  rd_addr;
    logic [7:0]     cur_byte;
    logic           last_byte;
    logic           beat_done;
    logic [7:0]     beat_bytes [NL];
    eblz_pkg::out_t beat;

    assign can_load  = !m_valid_reg || m_ready;
    assign wr_addr   = cmd_reg.base + AW'(k_reg);
    assign rd_addr   = wr_addr - AW'(cmd_reg.off);
    assign cur_byte  = cmd_reg.is_lit ? cmd_reg.lit_byte : rd_data_reg;
    assign last_byte = (k_reg == (cmd_reg.len - 8'd1));
    assign beat_done = last_byte || (lane_reg == LW'(NL - 1));

    always_comb begin
        for (int j = 0; j < NL; j++) begin
            if (LW'(j) < lane_reg) begin
                beat_bytes[j] = lanes_reg[j];
            end else if (LW'(j) == lane_reg) begin
                beat_bytes[j] = cur_byte;
            end else begin
                beat_bytes[j] = 8'd0;
            end
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        k_next     = k_reg;
        lane_next  = lane_reg;
        pop        = 1'b0;
        load_beat  = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        beat       = '0;

        case (state_reg)
            eblz_pkg::BK_IDLE: begin
                if (!q_flags.empty) begin
                    if (head.len == 8'd0) begin
                        // A status with no bytes leaves as a word of its own.
                        if (can_load) begin
                            pop           = 1'b1;
                            load_beat     = 1'b1;
                            beat.run_last = 1'b1;
                            beat.status   = head.status;
                        end
                    end else begin
                        pop        = 1'b1;
                        cmd_next   = head;
                        k_next     = 8'd0;
                        lane_next  = '0;
                        state_next = eblz_pkg::BK_READ;
                    end
                end
            end
            eblz_pkg::BK_READ: begin
                rd_en      = 1'b1;
                state_next = eblz_pkg::BK_WRITE;
            end
            eblz_pkg::BK_WRITE: begin
                if (!beat_done || can_load) begin
                    wr_en  = 1'b1;
                    k_next = k_reg + 8'd1;
                    if (beat_done) begin
                        load_beat      = 1'b1;
                        beat.out_byte0 = beat_bytes[0];
                        beat.out_byte1 = beat_bytes[1];
                        beat.out_byte2 = beat_bytes[2];
                        beat.out_byte3 = beat_bytes[3];
                        beat.out_count = 3'(lane_reg) + 3'd1;
                        if (last_byte && (cmd_reg.status != eblz_pkg::ST_RUNNING)) begin
                            beat.run_last = 1'b1;
                            beat.status   = cmd_reg.status;
                        end
                        lane_next = '0;
                    end else begin
                        lane_next = lane_reg + LW'(1);
                    end
                    if (last_byte) begin
                        if (!q_flags.empty && (head.len != 8'd0)) begin
                            pop        = 1'b1;
                            cmd_next   = head;
                            k_next     = 8'd0;
                            lane_next  = '0;
                            state_next = eblz_pkg::BK_READ;
                        end else begin
                            state_next = eblz_pkg::BK_IDLE;
                        end
                    end else begin
                        state_next = eblz_pkg::BK_READ;
                    end
                end
            end
            default: state_next = eblz_pkg::BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= eblz_pkg::BK_IDLE;
            k_reg       <= '0;
            lane_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            lane_reg  <= lane_next;
            if (load_beat) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
        if (load_beat) begin
            m_data_reg <= beat;
        end
        if (wr_en) begin
            lanes_reg[lane_reg] <= cur_byte;
        end
    end

    // History: the write of one byte lands before the read for the next one,
    // so a copy may overlap the bytes it is producing.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            hist_mem[wr_addr] <= cur_byte;
        end
        if (rd_en) begin
            rd_data_reg <= hist_mem[rd_addr];
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

/* rtl/escape_byte_lz_decoder_unit.sv */
// ---------------------------------------------------------------------------
// Escape-byte LZ decoder
// Decodes an escape-byte LZ stream with a 12-byte header into output words
// of up to four bytes, ending each stream with a status word.
// ---------------------------------------------------------------------------
// Input channel s_*: one compressed byte per word, in_last on the final byte
// of a buffer. Output channel m_*: up to four decoded bytes per word, unused
// lanes zero; the final word of a stream has run_last set and a nonzero
// status, and may carry no bytes at all.
// The front end takes an input word, then evaluates it, and takes no new word
// until the queue has room for its command. The back end does a history read,
// then a write, for each decoded byte, so a copy of n bytes leaves as
// ceil(n/4) words. A four-entry command queue lets the front end run ahead.
// When the receiver stalls, the output register holds its word, the back
// end waits, the queue fills and s_ready then drops.
// Reset clears all control state; the history memory is not cleared, which
// is never visible because a copy can only reach bytes already decoded in
// the current stream.
// ---------------------------------------------------------------------------
module escape_byte_lz_decoder_unit (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  eblz_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output eblz_pkg::out_t m_data
);

    logic               push;
    logic               pop;
    eblz_pkg::cmd_t     push_cmd;
    eblz_pkg::cmd_t     head;
    eblz_pkg::q_flags_t q_flags;

    eblz_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .push     (push),
        .push_cmd (push_cmd),
        .q_flags  (q_flags)
    );

    eblz_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .q_flags  (q_flags)
    );

    eblz_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_flags  (q_flags),
        .pop      (pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

/* rtl/eblz_checker.sv */
// ---------------------------------------------------------------------------
// Escape-byte LZ decoder checker
// Port-level assertions on the output words, bound to the top level.
// ---------------------------------------------------------------------------
module eblz_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           m_valid,
    input logic           m_ready,
    input eblz_pkg::out_t m_data
);

    // Valid, once offered, stays high until the word is taken.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("output word withdrawn before acceptance");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.out_count <= 3'd4))
        else $error("output lane count out of range");

    // Only the final word of a stream carries a status, and it always does.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.run_last == (m_data.status != eblz_pkg::ST_RUNNING)))
        else $error("status and run_last disagree");

    a_empty_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.out_count == 3'd0) |-> m_data.run_last)
        else $error("word without bytes that does not end a stream");

    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");

endmodule

bind escape_byte_lz_decoder_unit eblz_checker u_eblz_checker (.*);

/* tb/tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Escape-byte LZ decoder unit testbench
// Feeds compressed streams (headers, literals, escaped escapes, overlapping
// copies, and streams broken in every way the decoder reports) through the
// input channel under varying idle and stall patterns. Each accepted byte is
// run through a local decoder model whose output words are queued and
// compared field by field with the words the unit returns.
// ---------------------------------------------------------------------------
module tb;

    localparam int WATCHDOG_LIMIT = 4000;

    typedef enum int {
        SK_CLEAN,
        SK_EARLY_END,
        SK_HDR_SHORT,
        SK_CUT,
        SK_ZERO_OFF,
        SK_BEFORE_START,
        SK_OVERFLOW,
        SK_SHORTFALL,
        SK_NOISE,
        SK_WIDE_ESC,
        SK_KIND_COUNT
    } stream_kind_t;

    logic           aclk    = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_valid = 1'b0;
    logic           s_ready;
    eblz_pkg::in_t  s_data  = '0;
    logic           m_valid;
    logic           m_ready = 1'b0;
    eblz_pkg::out_t m_data;

    // Decoder model state.
    logic [7:0]        hist_mem [eblz_pkg::HIST_DEPTH];
    logic [31:0]       hdr_expected_size;
    logic [31:0]       hdr_source_size;
    logic [31:0]       hdr_escape;
    logic [31:0]       src_pos;
    logic [31:0]       out_pos;
    eblz_pkg::phase_t  tok_phase;
    logic [7:0]        pending_offset;
    logic              stream_ended;
    eblz_pkg::status_t end_status;
    logic [7:0]        new_bytes [$];

    eblz_pkg::out_t    expected_words [$];
    logic [7:0]        body_bytes [$];
    logic [7:0]        stream_bytes [$];

    int fail_count         = 0;
    int live_items         = 0;
    int streams_built      = 0;
    int sender_gap_pct     = 0;
    int receiver_stall_pct = 0;
    int receiver_hold_left = 0;
    int quiet_cycles       = 0;

    escape_byte_lz_decoder_unit u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Decoder model
    // ------------------------------------------------------------------
    function automatic void rearm_stream();
        hdr_expected_size = '0;
        hdr_source_size   = '0;
        hdr_escape        = '0;
        src_pos           = '0;
        out_pos           = '0;
        tok_phase         = eblz_pkg::PH_TOKEN;
        pending_offset    = '0;
        stream_ended      = 1'b0;
    endfunction

    function automatic void end_stream(input eblz_pkg::status_t st);
        end_status   = st;
        stream_ended = 1'b1;
    endfunction

    function automatic void emit_byte(input logic [7:0] value);
        hist_mem[out_pos[eblz_pkg::HIST_AW-1:0]] = value;
        out_pos = out_pos + 1;
        new_bytes.push_back(value);
    endfunction

    // Checks made after the header and after every completed token.
    function automatic void close_token(input logic last);
        if (src_pos >= hdr_source_size)
            end_stream(out_pos == hdr_expected_size ? eblz_pkg::ST_DONE_OK
                                                    : eblz_pkg::ST_SIZE_MISMATCH);
        else if (out_pos >= hdr_expected_size)
            end_stream(eblz_pkg::ST_OVERFLOW);
        else if (last)
            end_stream(eblz_pkg::ST_TRUNCATED);
    endfunction

    function automatic void decode_stream_byte(input logic [7:0] b, input logic last);
        logic [31:0]    off;
        logic [31:0]    len;
        logic [31:0]    src;
        logic [7:0]     lane [eblz_pkg::LANES];
        eblz_pkg::out_t w;
        int             beats;
        int             base;
        int             cnt;
        int             k;
        int             j;
        new_bytes.delete();
        end_status = eblz_pkg::ST_RUNNING;
        // A finished stream swallows bytes up to and including its in_last.
        if (stream_ended) begin
            if (last)
                rearm_stream();
            return;
        end
        if (src_pos < eblz_pkg::HEADER_BYTES) begin
            case (src_pos[3:2])
                2'd0:    hdr_expected_size |= 32'(b) << (8 * src_pos[1:0]);
                2'd1:    hdr_source_size   |= 32'(b) << (8 * src_pos[1:0]);
                default: hdr_escape        |= 32'(b) << (8 * src_pos[1:0]);
            endcase
            src_pos = src_pos + 1;
            if (src_pos == eblz_pkg::HEADER_BYTES)
                close_token(last);
            else if (last)
                end_stream(eblz_pkg::ST_HDR_SHORT);
        end else begin
            if (src_pos != 32'hFFFF_FFFF)
                src_pos = src_pos + 1;
            case (tok_phase)
                eblz_pkg::PH_TOKEN: begin
                    if (32'(b) == hdr_escape) begin
                        tok_phase = eblz_pkg::PH_ESCAPE;
                        if (last)
                            end_stream(eblz_pkg::ST_TRUNCATED);
                    end else begin
                        emit_byte(b);
                        close_token(last);
                    end
                end
                eblz_pkg::PH_ESCAPE: begin
                    if (32'(b) == hdr_escape) begin
                        emit_byte(b);
                        tok_phase = eblz_pkg::PH_TOKEN;
                        close_token(last);
                    end else begin
                        // Offsets at or above the escape value are stored one higher.
                        off = 32'(b);
                        if (hdr_escape < off)
                            off = off - 1;
                        if (off == 0) begin
                            end_stream(eblz_pkg::ST_ZERO_OFFSET);
                        end else begin
                            pending_offset = off[7:0];
                            tok_phase      = eblz_pkg::PH_LENGTH;
                            if (last)
                                end_stream(eblz_pkg::ST_TRUNCATED);
                        end
                    end
                end
                default: begin
                    len       = 32'(b);
                    tok_phase = eblz_pkg::PH_TOKEN;
                    if (len != 0) begin
                        if (out_pos < 32'(pending_offset)) begin
                            end_stream(eblz_pkg::ST_BEFORE_START);
                        end else if (33'(out_pos) + 33'(len) > 33'(hdr_expected_size)) begin
                            end_stream(eblz_pkg::ST_OVERFLOW);
                        end else begin
                            // Byte by byte, so an overlapping copy reads what it has just written.
                            for (k = 0; k < len; k++) begin
                                src = out_pos - 32'(pending_offset);
                                emit_byte(hist_mem[src[eblz_pkg::HIST_AW-1:0]]);
                            end
                        end
                    end
                    if (!stream_ended)
                        close_token(last);
                end
            endcase
        end

        beats = (new_bytes.size() + eblz_pkg::LANES - 1) / eblz_pkg::LANES;
        if (end_status != eblz_pkg::ST_RUNNING && beats == 0)
            beats = 1;
        for (k = 0; k < beats; k++) begin
            base = k * eblz_pkg::LANES;
            cnt  = 0;
            for (j = 0; j < eblz_pkg::LANES; j++) begin
                if (base + j < new_bytes.size()) begin
                    lane[j] = new_bytes[base + j];
                    cnt++;
                end else begin
                    lane[j] = 8'h00;
                end
            end
            w.out_byte0 = lane[0];
            w.out_byte1 = lane[1];
            w.out_byte2 = lane[2];
            w.out_byte3 = lane[3];
            w.out_count = 3'(cnt);
            w.run_last  = (k == beats - 1) && (end_status != eblz_pkg::ST_RUNNING);
            w.status    = w.run_last ? end_status : eblz_pkg::ST_RUNNING;
            expected_words.push_back(w);
        end
        if (end_status != eblz_pkg::ST_RUNNING && last)
            rearm_stream();
    endfunction

    initial begin : model_init
        foreach (hist_mem[i])
            hist_mem[i] = 8'h00;
        rearm_stream();
    end

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    function automatic string word_text(input eblz_pkg::out_t w);
        return $sformatf("bytes %h %h %h %h count %0d run_last %0b status %0d",
                         w.out_byte0, w.out_byte1, w.out_byte2, w.out_byte3,
                         w.out_count, w.run_last, w.status);
    endfunction

    function automatic void note_failure(input string what, input eblz_pkg::out_t want,
                                         input eblz_pkg::out_t got);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s: expected %s, got %s", $realtime, what,
                     word_text(want), word_text(got));
    endfunction

    always @(posedge aclk) begin : result_checker
        eblz_pkg::out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_words.size() == 0) begin
                note_failure("word with nothing expected", '0, m_data);
            end else begin
                want = expected_words.pop_front();
                if (m_data.out_byte0 !== want.out_byte0 || m_data.out_byte1 !== want.out_byte1 ||
                    m_data.out_byte2 !== want.out_byte2 || m_data.out_byte3 !== want.out_byte3 ||
                    m_data.out_count !== want.out_count || m_data.run_last !== want.run_last ||
                    m_data.status !== want.status)
                    note_failure("mismatch", want, m_data);
            end
        end
    end

    // The receiver either stalls at random or holds off for a counted stretch.
    always @(posedge aclk) begin : receiver
        if (receiver_hold_left > 0) begin
            m_ready <= 1'b0;
            receiver_hold_left = receiver_hold_left - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] value, input logic last);
        while ($urandom_range(99) < sender_gap_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_data.in_byte <= value;
        s_data.in_last <= last;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        if (!stream_ended)
            live_items++;
        decode_stream_byte(value, last);
    endtask

    task automatic send_stream();
        for (int i = 0; i < stream_bytes.size(); i++)
            send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
    endtask

    // The task waits on the clock after valid is lowered, so it is never raised in the same step.
    task automatic pause_until_drained();
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (expected_words.size() != 0);
    endtask

    function automatic logic [7:0] encode_offset(input int span, input logic [31:0] esc);
        return (32'(span) < esc) ? 8'(span) : 8'(span + 1);
    endfunction

    task automatic build_stream(input stream_kind_t kind);
        logic [31:0] esc;
        logic [31:0] exp_size;
        logic [31:0] src_size;
        int          n_out;
        int          n_tok;
        int          span;
        int          len;
        int          r;
        logic [7:0]  b;
        body_bytes.delete();
        stream_bytes.delete();
        r = $urandom_range(9);
        esc = (r == 0) ? 32'd0 : (r == 1) ? 32'd255 : 32'($urandom_range(255));
        if (kind == SK_WIDE_ESC)
            esc = $urandom | 32'h100;
        n_out = 0;
        n_tok = $urandom_range(16, 1);
        for (int t = 0; t < n_tok; t++) begin
            r = $urandom_range(99);
            if (esc > 255 || r < 45 || n_out == 0) begin
                b = $urandom_range(255);
                body_bytes.push_back(b);
                if (esc <= 255 && b == esc[7:0])
                    body_bytes.push_back(b);
                n_out++;
            end else if (r < 55) begin
                body_bytes.push_back(esc[7:0]);
                body_bytes.push_back(esc[7:0]);
                n_out++;
            end else begin
                span = $urandom_range(n_out < 254 ? n_out : 254, 1);
                len  = ($urandom_range(99) < 3) ? $urandom_range(255, 13) : $urandom_range(12);
                body_bytes.push_back(esc[7:0]);
                body_bytes.push_back(encode_offset(span, esc));
                body_bytes.push_back(8'(len));
                n_out += len;
            end
        end

        if (kind == SK_ZERO_OFF) begin
            body_bytes.push_back(esc[7:0]);
            body_bytes.push_back(esc == 0 ? 8'd1 : 8'd0);
        end else if (kind == SK_BEFORE_START && n_out < 254) begin
            body_bytes.push_back(esc[7:0]);
            body_bytes.push_back(encode_offset($urandom_range(254, n_out + 1), esc));
            body_bytes.push_back(8'($urandom_range(10, 1)));
        end

        exp_size = n_out;
        src_size = 12 + body_bytes.size();
        case (kind)
            SK_EARLY_END: src_size = 12 + $urandom_range(body_bytes.size());
            SK_OVERFLOW:  exp_size = n_out - $urandom_range(n_out, 1);
            SK_SHORTFALL: exp_size = n_out + $urandom_range(300, 1);
            SK_NOISE: begin
                exp_size = $urandom_range(1) ? $urandom : $urandom_range(64);
                src_size = $urandom_range(1) ? $urandom : 12 + $urandom_range(40);
                esc      = $urandom_range(1) ? $urandom : $urandom_range(255);
                body_bytes.delete();
                repeat ($urandom_range(30))
                    body_bytes.push_back(8'($urandom));
            end
            default: ;
        endcase

        // Bytes beyond the end of a broken stream must be ignored until in_last.
        if (kind == SK_EARLY_END || kind == SK_ZERO_OFF || kind == SK_BEFORE_START)
            repeat ($urandom_range(4, 1))
                body_bytes.push_back(8'($urandom));

        for (int i = 0; i < 4; i++)
            stream_bytes.push_back(8'(exp_size >> (8 * i)));
        for (int i = 0; i < 4; i++)
            stream_bytes.push_back(8'(src_size >> (8 * i)));
        for (int i = 0; i < 4; i++)
            stream_bytes.push_back(8'(esc >> (8 * i)));
        foreach (body_bytes[i])
            stream_bytes.push_back(body_bytes[i]);

        if (kind == SK_CUT && body_bytes.size() > 0)
            r = 12 + $urandom_range(body_bytes.size() - 1);
        else if (kind == SK_HDR_SHORT)
            r = $urandom_range(11, 1);
        else
            r = stream_bytes.size();
        while (stream_bytes.size() > r)
            void'(stream_bytes.pop_back());
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Literals 00 and 7E, an escaped escape, a copy of length zero and an
    // overlapping copy of five, then a stream whose header is cut short.
    task automatic test_directed_tokens();
        logic [7:0] tokens [25] = '{
            8'h08, 8'h00, 8'h00, 8'h00, 8'h16, 8'h00, 8'h00, 8'h00,
            8'hFF, 8'h00, 8'h00, 8'h00,
            8'h00, 8'h7E, 8'hFF, 8'hFF, 8'hFF, 8'h02, 8'h00, 8'hFF, 8'h01, 8'h05,
            8'h03, 8'h00, 8'h00
        };
        sender_gap_pct     = 0;
        receiver_stall_pct = 0;
        for (int i = 0; i < 25; i++)
            send_byte(tokens[i], i == 21 || i == 24);
    endtask

    task automatic test_random_streams(input int n_items, input int gap_pct,
                                       input int stall_pct);
        int           start_count;
        stream_kind_t kind;
        sender_gap_pct     = gap_pct;
        receiver_stall_pct = stall_pct;
        start_count        = live_items;
        while (live_items - start_count < n_items) begin
            // Every kind of stream once, then clean ones half the time.
            if (streams_built < SK_KIND_COUNT)
                kind = stream_kind_t'(streams_built);
            else if ($urandom_range(99) < 50)
                kind = SK_CLEAN;
            else
                kind = stream_kind_t'($urandom_range(SK_KIND_COUNT - 1, 1));
            streams_built++;
            build_stream(kind);
            send_stream();
        end
    endtask

    // The receiver holds off long enough for the command queue to fill and
    // the input to stall while words keep being offered.
    task automatic test_output_backpressure();
        sender_gap_pct     = 0;
        receiver_stall_pct = 0;
        receiver_hold_left = 400;
        repeat (3) begin
            build_stream(SK_CLEAN);
            send_stream();
        end
        pause_until_drained();
    endtask

    task automatic test_sender_pause();
        sender_gap_pct     = 0;
        receiver_stall_pct = 0;
        build_stream(SK_CLEAN);
        send_stream();
        pause_until_drained();
        build_stream(SK_CLEAN);
        send_stream();
    endtask

    initial begin : test_sequence
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed_tokens();
        test_random_streams(45, 0, 0);
        test_random_streams(45, 53, 0);
        test_output_backpressure();
        test_random_streams(45, 0, 53);
        test_sender_pause();
        test_random_streams(45, 31, 31);
        pause_until_drained();
        repeat (30) @(posedge aclk);
        if (expected_words.size() != 0)
            note_failure("word never returned", expected_words[0], '0);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* filelist.f */
rtl/eblz_pkg.sv
rtl/eblz_front.sv
rtl/eblz_fifo.sv
rtl/eblz_back.sv
rtl/escape_byte_lz_decoder_unit.sv
rtl/eblz_checker.sv
tb/tb.sv
